### design/bmp24_pkg.sv
// Shared types, constants and header offsets of the 24-bit BMP stream parser.
package bmp24_pkg;

  localparam int unsigned DIM_BITS = 16;
  localparam int unsigned W3_W     = DIM_BITS + 2;
  localparam int unsigned PROD_W   = 2 * DIM_BITS - 1;
  localparam int unsigned CMP_W    = (PROD_W > 32) ? PROD_W : 32;

  localparam logic [31:0] POS_SIG    = 32'd1;
  localparam logic [31:0] POS_OFFSET = 32'd13;
  localparam logic [31:0] POS_HSIZE  = 32'd17;
  localparam logic [31:0] POS_WIDTH  = 32'd21;
  localparam logic [31:0] POS_HEIGHT = 32'd25;
  localparam logic [31:0] POS_PLANES = 32'd27;
  localparam logic [31:0] POS_DEPTH  = 32'd29;
  localparam logic [31:0] POS_COMP   = 32'd33;

  localparam logic [15:0] SIGNATURE_BM = 16'h4D42;
  localparam logic [31:0] MIN_OFFSET   = 32'd34;
  localparam logic [31:0] INFO_SIZE    = 32'd40;
  localparam logic [15:0] NUM_PLANES   = 16'd1;
  localparam logic [15:0] BIT_DEPTH    = 16'd24;
  localparam logic [31:0] BI_RGB       = 32'd0;
  localparam logic [1:0]  IDX_LAST     = 2'd2;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_DATA,
    PH_DONE,
    PH_ERROR
  } phase_e;

  typedef enum logic [3:0] {
    ERR_NONE        = 4'd0,
    ERR_SIGNATURE   = 4'd1,
    ERR_OFFSET      = 4'd2,
    ERR_HDR_SIZE    = 4'd3,
    ERR_PLANES      = 4'd4,
    ERR_DEPTH       = 4'd5,
    ERR_COMPRESSION = 4'd6,
    ERR_SIZE        = 4'd7,
    ERR_TOO_LARGE   = 4'd8,
    ERR_TRUNCATED   = 4'd9
  } err_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  chan_first;
    logic [7:0]  chan_second;
    logic [7:0]  chan_third;
    logic [15:0] pixel_row;
    logic [15:0] pixel_col;
    logic        last_pixel;
    err_e        error_code;
  } result_t;

endpackage

### design/bmp24_in_stage.sv
// Input register that holds one byte transfer until the parser takes it.
module bmp24_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               end_of_file_i,
  input  logic               take_i,
  output logic               item_valid_o,
  output bmp24_pkg::in_item_t item_o
);
  import bmp24_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q, item_d;

  assign in_stall_o = valid_q & ~take_i;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (!in_stall_o) begin
      valid_d = in_valid_i;
      if (in_valid_i) begin
        item_d.data_byte   = data_byte_i;
        item_d.end_of_file = end_of_file_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

### design/bmp24_parse.sv
// Header checks, pixel grouping and position counters of the BMP parser.
module bmp24_parse (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                fire_i,
  input  bmp24_pkg::in_item_t item_i,
  output logic                res_valid_o,
  output bmp24_pkg::result_t  res_o
);
  import bmp24_pkg::*;

  phase_e              phase_q, phase_d, phase_mid;
  logic [31:0]         file_len_q;
  logic [31:0]         pos_q, pos_d;
  logic [31:0]         offset_q, offset_d;
  logic [31:0]         hw_q, hw_d, hw_next;
  logic [DIM_BITS-1:0] width_q, width_d;
  logic [DIM_BITS-1:0] height_q, height_d;
  logic [DIM_BITS-1:0] row_q, row_d;
  logic [DIM_BITS-1:0] col_q, col_d;
  logic [1:0]          idx_q, idx_d;
  logic [15:0]         held_q, held_d;
  logic [1:0]          pad_q, pad_d;
  logic [PROD_W-1:0]   prod_q;
  logic [W3_W-1:0]     w3;
  logic [DIM_BITS:0]   col_inc, row_inc;
  logic                in_data, pix_emit, col_wrap, row_wrap, last_pix;
  err_e                hdr_code, code;

  assign hw_next = {item_i.data_byte, hw_q[31:8]};

  // The size product is refreshed every cycle and is settled long before the last header byte.
  assign w3 = W3_W'(width_q) + W3_W'({width_q, 1'b0});

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(w3[W3_W-1:3]) * PROD_W'(height_q);
  end

  always_comb begin
    hdr_code = ERR_NONE;
    if (phase_q == PH_HEADER) begin
      case (pos_q)
        POS_SIG: begin
          if (hw_next[31:16] != SIGNATURE_BM) hdr_code = ERR_SIGNATURE;
        end
        POS_OFFSET: begin
          if (hw_next > file_len_q || hw_next < MIN_OFFSET) hdr_code = ERR_OFFSET;
        end
        POS_HSIZE: begin
          if (hw_next != INFO_SIZE) hdr_code = ERR_HDR_SIZE;
        end
        POS_WIDTH, POS_HEIGHT: begin
          if (|hw_next[31:DIM_BITS]) hdr_code = ERR_TOO_LARGE;
        end
        POS_PLANES: begin
          if (hw_next[31:16] != NUM_PLANES) hdr_code = ERR_PLANES;
        end
        POS_DEPTH: begin
          if (hw_next[31:16] != BIT_DEPTH) hdr_code = ERR_DEPTH;
        end
        POS_COMP: begin
          if (hw_next != BI_RGB) begin
            hdr_code = ERR_COMPRESSION;
          end else if (CMP_W'(prod_q) > CMP_W'(file_len_q)) begin
            hdr_code = ERR_SIZE;
          end
        end
        default: begin
          hdr_code = ERR_NONE;
        end
      endcase
    end
  end

  assign in_data  = (phase_q == PH_DATA) && (pos_q >= offset_q);
  assign pix_emit = in_data && (pad_q == 2'd0) && (idx_q == IDX_LAST);
  assign col_inc  = (DIM_BITS + 1)'(col_q) + 1'b1;
  assign row_inc  = (DIM_BITS + 1)'(row_q) + 1'b1;
  assign col_wrap = col_inc >= (DIM_BITS + 1)'(width_q);
  assign row_wrap = row_inc >= (DIM_BITS + 1)'(height_q);
  assign last_pix = pix_emit && col_wrap && row_wrap;

  always_comb begin
    phase_mid = phase_q;
    if (phase_q == PH_HEADER && pos_q == POS_COMP && hdr_code == ERR_NONE) begin
      phase_mid = (width_q != '0 && height_q != '0) ? PH_DATA : PH_DONE;
    end else if (last_pix) begin
      phase_mid = PH_DONE;
    end
  end

  always_comb begin
    phase_d = phase_q;
    if (fire_i) begin
      if (item_i.end_of_file) begin
        phase_d = PH_HEADER;
      end else if (hdr_code != ERR_NONE) begin
        phase_d = PH_ERROR;
      end else begin
        phase_d = phase_mid;
      end
    end
  end

  always_comb begin
    code = hdr_code;
    if (hdr_code == ERR_NONE && item_i.end_of_file &&
        (phase_mid == PH_HEADER || phase_mid == PH_DATA)) begin
      code = ERR_TRUNCATED;
    end
  end

  always_comb begin
    pos_d    = pos_q;
    offset_d = offset_q;
    hw_d     = hw_q;
    width_d  = width_q;
    height_d = height_q;
    row_d    = row_q;
    col_d    = col_q;
    idx_d    = idx_q;
    held_d   = held_q;
    pad_d    = pad_q;
    if (fire_i) begin
      if (pos_q != '1) pos_d = pos_q + 32'd1;
      if (phase_q == PH_HEADER) begin
        hw_d = hw_next;
        if (pos_q == POS_OFFSET) offset_d = hw_next;
        if (pos_q == POS_WIDTH && hdr_code == ERR_NONE) width_d = hw_next[DIM_BITS-1:0];
        if (pos_q == POS_HEIGHT && hdr_code == ERR_NONE) height_d = hw_next[DIM_BITS-1:0];
      end else if (in_data) begin
        if (pad_q != 2'd0) begin
          pad_d = pad_q - 2'd1;
        end else if (idx_q != IDX_LAST) begin
          if (idx_q == 2'd0) begin
            held_d = {8'd0, item_i.data_byte};
          end else begin
            held_d[15:8] = item_i.data_byte;
          end
          idx_d = idx_q + 2'd1;
        end else begin
          idx_d = 2'd0;
          if (col_wrap) begin
            col_d = '0;
            if (!row_wrap) begin
              row_d = row_q + 1'b1;
              pad_d = width_q[1:0];
            end
          end else begin
            col_d = col_q + 1'b1;
          end
        end
      end
      if (item_i.end_of_file) begin
        pos_d    = '0;
        offset_d = '0;
        hw_d     = '0;
        width_d  = '0;
        height_d = '0;
        row_d    = '0;
        col_d    = '0;
        idx_d    = '0;
        held_d   = '0;
        pad_d    = '0;
      end
    end
  end

  always_comb begin
    res_valid_o = fire_i && (pix_emit || code != ERR_NONE);
    res_o       = '0;
    if (code != ERR_NONE) begin
      res_o.error_code = code;
    end else begin
      res_o.chan_first  = held_q[7:0];
      res_o.chan_second = held_q[15:8];
      res_o.chan_third  = item_i.data_byte;
      res_o.pixel_row   = 16'(row_q);
      res_o.pixel_col   = 16'(col_q);
      res_o.last_pixel  = last_pix;
      res_o.error_code  = ERR_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      file_len_q <= '0;
      pos_q      <= '0;
      offset_q   <= '0;
      hw_q       <= '0;
      width_q    <= '0;
      height_q   <= '0;
      row_q      <= '0;
      col_q      <= '0;
      idx_q      <= '0;
      held_q     <= '0;
      pad_q      <= '0;
    end else begin
      phase_q    <= phase_d;
      if (cfg_we_i) file_len_q <= cfg_wdata_i;
      pos_q      <= pos_d;
      offset_q   <= offset_d;
      hw_q       <= hw_d;
      width_q    <= width_d;
      height_q   <= height_d;
      row_q      <= row_d;
      col_q      <= col_d;
      idx_q      <= idx_d;
      held_q     <= held_d;
      pad_q      <= pad_d;
    end
  end

endmodule

### design/bmp24_out_stage.sv
// Result register that holds one pixel or error transfer for the receiver.
module bmp24_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  bmp24_pkg::result_t res_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bmp24_pkg::result_t res_o
);
  import bmp24_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o = ~valid_q | ~out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (free_o) valid_d = load_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) res_q <= res_i;
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

### design/bmp24_stream_parser.sv
// Top level of the 24-bit BMP stream parser.
// The parser takes one file byte per transfer and can accept a byte in every cycle unless the
// input is stalled. A byte goes into an input register and is parsed combinationally once the
// output register is free; its result, if any, is loaded into the output register. When the
// receiver stalls a waiting result, the input register fills and then the input stalls too.
// One result is given per completed pixel, and an error result (all other fields zero) reports
// the first header problem or a stream that ends early. The end-of-file flag rearms the parser
// for the next file; file_length is kept.
module bmp24_stream_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_file_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  chan_first_o,
  output logic [7:0]  chan_second_o,
  output logic [7:0]  chan_third_o,
  output logic [15:0] pixel_row_o,
  output logic [15:0] pixel_col_o,
  output logic        last_pixel_o,
  output logic [3:0]  error_code_o
);
  import bmp24_pkg::*;

  logic     item_valid, out_free, fire, res_valid;
  in_item_t item;
  result_t  res, res_out;

  assign fire = item_valid & out_free;

  bmp24_in_stage u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .end_of_file_i (end_of_file_i),
    .take_i        (out_free),
    .item_valid_o  (item_valid),
    .item_o        (item)
  );

  bmp24_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  bmp24_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign chan_first_o  = res_out.chan_first;
  assign chan_second_o = res_out.chan_second;
  assign chan_third_o  = res_out.chan_third;
  assign pixel_row_o   = res_out.pixel_row;
  assign pixel_col_o   = res_out.pixel_col;
  assign last_pixel_o  = res_out.last_pixel;
  assign error_code_o  = res_out.error_code;

  a_stall_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (item_valid && out_valid_o && out_stall_i))
    else $error("input stalled while the result register could move");

  a_error_clears_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && error_code_o != ERR_NONE) |->
      (chan_first_o == 8'd0 && chan_second_o == 8'd0 && chan_third_o == 8'd0 &&
       pixel_row_o == 16'd0 && pixel_col_o == 16'd0 && !last_pixel_o))
    else $error("error transfer carries pixel data");

  a_code_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (error_code_o <= ERR_TRUNCATED))
    else $error("error code out of range");

  a_fire_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> item_valid)
    else $error("result produced without a held input byte");

endmodule
